@@ sv/strict_priority_packet_queues_assert.svh @@
// Assertion macros shared by the queue scheduler.
`ifndef STRICT_PRIORITY_PACKET_QUEUES_ASSERT_SVH
`define STRICT_PRIORITY_PACKET_QUEUES_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Invariant checked on every rising clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`endif

@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types of the strict priority packet queues.
// ----------------------------------------------------------------------------
`default_nettype none
package spq_pkg;
	localparam int PRIORITY_LEVELS = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_SEND = 64;
	localparam int PW = $clog2(PRIORITY_LEVELS);
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_RECEIVE = 1'b0;
	localparam logic KIND_SEND = 1'b1;

	typedef logic [15:0] id_t;

	typedef struct packed {
		logic kind;
		logic [15:0] packet_id;
		logic [2:0] packet_priority;
		logic [6:0] send_count;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] out_id;
		logic [2:0] out_priority;
		logic last;
	} out_beat_t;

	// Per-cell commands issued by the controller to one queue.
	typedef struct packed {
		logic push;     // append din at the tail
		logic pop;      // remove the head
		logic thin;     // one compaction step
		logic thin_end; // compaction finished, shrink length
	} cell_cmd_t;
endpackage
`default_nettype wire

@@ sv/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface spq_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/spq_queue_cell.sv @@
// ----------------------------------------------------------------------------
// spq_queue_cell
// One priority level: a shift-register FIFO with in-place thinning.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_queue_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire spq_pkg::cell_cmd_t cmd,
	input wire spq_pkg::id_t din,
	input wire logic [spq_pkg::DW-1:0] thin_k,
	output spq_pkg::id_t head_id,
	output logic [spq_pkg::LW-1:0] len
);
	import spq_pkg::*;

	// Entries shift toward slot 0 on a pop: slot 0 is always the oldest.
	id_t slot_q [QUEUE_DEPTH];
	logic [LW-1:0] len_q;
	logic [DW:0] src;

	assign head_id = slot_q[0];
	assign len = len_q;
	assign src = {thin_k, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) slot_q[i] <= slot_q[i + 1];
		end else if (cmd.push) begin
			slot_q[len_q[DW-1:0]] <= din;
		end else if (cmd.thin) begin
			slot_q[thin_k] <= slot_q[src[DW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.pop) begin
			len_q <= len_q - 1'b1;
		end else if (cmd.push) begin
			len_q <= len_q + 1'b1;
		end else if (cmd.thin_end) begin
			len_q <= LW'((len_q + 1'b1) >> 1);
		end
	end
endmodule
`default_nettype wire

@@ sv/strict_priority_packet_queues.sv @@
// ----------------------------------------------------------------------------
// strict_priority_packet_queues
// Per-priority packet FIFOs with strict priority dequeue.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch (valid/ready). A receive beat (kind 0) appends
// packet_id to the FIFO of packet_priority; a send beat (kind 1) asks for up
// to send_count packets, which leave on out_ch highest priority first and
// oldest first, last set on the final one. A send that finds nothing, or a
// count of zero, produces no output beat.
// A receive into a queue below the limit is accepted and then pushed from
// the pending-push register; when the queue is at the limit it is thinned
// first, one kept entry per cycle, and then pushed. The send rate is set
// by the single output register and the per-cycle priority search over
// the row of queue cells. queue_limit is written through cfg_we/cfg_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Reset clears all queue lengths and sets
// queue_limit to 16; no clearing pass is needed. When the receiver stalls,
// the output register holds the beat and the scheduler waits; no packet is
// lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strict_priority_packet_queues_assert.svh"
module strict_priority_packet_queues (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_data,
	spq_if.sink in_ch,
	spq_if.source out_ch
);
	import spq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_THIN = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	logic [1:0] state_q;
	logic [4:0] limit_q;
	logic [PW-1:0] prio_q;
	id_t id_q;
	logic [6:0] want_q;
	logic [DW-1:0] k_q;
	out_beat_t obuf_q;
	logic ovalid_q;

	cell_cmd_t cmd [PRIORITY_LEVELS];
	id_t head_id [PRIORITY_LEVELS];
	logic [LW-1:0] len [PRIORITY_LEVELS];

	// A pending push is committed in the cycle after acceptance or thinning.
	logic push_now;
	logic push_q;
	logic push_d;
	assign push_now = push_q;

	in_beat_t ib;
	assign ib = in_ch.payload;

	// Effective limit: zero acts as one, above the depth acts as the depth.
	logic [LW-1:0] lim;
	always_comb begin
		if (limit_q == 5'd0) lim = LW'(1);
		else if ({1'b0, limit_q} > 6'(QUEUE_DEPTH)) lim = LW'(QUEUE_DEPTH);
		else lim = LW'(limit_q);
	end

	// Highest non-empty priority.
	logic any_pkt;
	logic [PW-1:0] top;
	always_comb begin
		any_pkt = 1'b0;
		top = '0;
		for (int p = 0; p < PRIORITY_LEVELS; p++) begin
			if (len[p] != '0) begin
				any_pkt = 1'b1;
				top = PW'(p);
			end
		end
	end

	// Some packet queued at a priority other than the top one.
	logic multi;
	always_comb begin
		multi = 1'b0;
		for (int p = 0; p < PRIORITY_LEVELS; p++) begin
			if (PW'(p) != top && len[p] != '0) multi = 1'b1;
		end
	end

	logic [PW-1:0] in_prio;
	assign in_prio = (int'(ib.packet_priority) >= PRIORITY_LEVELS) ?
		PW'(PRIORITY_LEVELS - 1) : PW'(ib.packet_priority);

	// The input is closed while a push is pending, since the queue length
	// seen by the next receive must already include that push.
	logic obuf_free;
	assign obuf_free = !ovalid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !push_q;

	logic emit;
	assign emit = (state_q == ST_SEND) && obuf_free && any_pkt && (want_q != '0);

	always_comb begin
		for (int p = 0; p < PRIORITY_LEVELS; p++) begin
			cmd[p] = '0;
			if (PW'(p) == prio_q && state_q == ST_THIN) begin
				if ({1'b0, k_q, 1'b0} < {1'b0, len[p]} && k_q != '0) cmd[p].thin = 1'b1;
				else begin
					cmd[p].thin_end = 1'b1;
				end
			end
			if (PW'(p) == top && emit) cmd[p].pop = 1'b1;
		end
	end

	// A receive below the limit pushes right after acceptance; one at the
	// limit pushes right after the compaction has finished.
	assign push_d = ((state_q == ST_IDLE) && in_ch.valid && in_ch.ready &&
		(ib.kind == KIND_RECEIVE) && (len[in_prio] < lim)) ||
		((state_q == ST_THIN) && !cmd[prio_q].thin);

	genvar g;
	generate
		for (g = 0; g < PRIORITY_LEVELS; g++) begin : g_cell
			cell_cmd_t c;
			always_comb begin
				c = cmd[g];
				c.push = (state_q == ST_IDLE) && push_now && (prio_q == PW'(g));
			end
			spq_queue_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(c), .din(id_q),
				.thin_k(k_q), .head_id(head_id[g]), .len(len[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= 5'd16;
			push_q <= 1'b0;
			ovalid_q <= 1'b0;
			want_q <= '0;
			k_q <= '0;
			prio_q <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			push_q <= push_d;
			if (emit) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (ib.kind == KIND_RECEIVE) begin
							prio_q <= in_prio;
							if (len[in_prio] >= lim) begin
								k_q <= DW'(1);
								state_q <= ST_THIN;
							end
						end else begin
							want_q <= (int'(ib.send_count) > MAX_SEND) ?
								7'(MAX_SEND) : ib.send_count;
							state_q <= ST_SEND;
						end
					end
				end
				ST_THIN: begin
					if (cmd[prio_q].thin) k_q <= k_q + 1'b1;
					else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEND: begin
					if (emit) begin
						want_q <= want_q - 1'b1;
						if (want_q == 7'd1 || (len[top] == LW'(1) && !multi)) begin
							state_q <= ST_IDLE;
						end
					end else if (!any_pkt || want_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) id_q <= ib.packet_id;
		if (emit) begin
			obuf_q.out_id <= head_id[top];
			obuf_q.out_priority <= 3'(top);
			obuf_q.last <= (want_q == 7'd1) || (len[top] == LW'(1) && !multi);
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.payload = obuf_q;

	`SPQ_ASSERT_IMP(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, ##1 out_ch.valid)
	`SPQ_ASSERT_IMP(a_emit_room, clk, arst_n, emit, obuf_free)
	`SPQ_ASSERT_ALWAYS(a_busy, clk, arst_n, (state_q == ST_IDLE) || !in_ch.ready)
endmodule
`default_nettype wire
